// ===== rtl/rpt_pkg.sv =====
// ============================================================================
// rpt_pkg
// Shared types and constants for the route prefix table: field widths,
// request and status codes, and the packed layout of one stored route.
// ============================================================================
`default_nettype none

package rpt_pkg;

    // Field widths of the request and result items
    localparam int ADDR_W    = 32;
    localparam int PREFIX_W  = 6;
    localparam int REACH_W   = 8;
    localparam int INDEX_W   = 3;
    localparam int COUNT_W   = 4;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;

    // Default number of table slots
    localparam int TABLE_DEPTH_DEF = 8;

    // All-ones address, source of the prefix mask
    localparam logic [ADDR_W-1:0] ADDR_ONES = 32'hFFFF_FFFF;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIND   = 2'd2,
        REQ_MARK   = 2'd3
    } req_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_BADIDX  = 2'd3
    } status_t;

    // One stored route
    typedef struct packed {
        logic [ADDR_W-1:0]   network;
        logic [PREFIX_W-1:0] prefix;
        logic [ADDR_W-1:0]   router;
        logic [REACH_W-1:0]  reach;
    } route_entry_t;

endpackage

`default_nettype wire

// ===== rtl/route_prefix_table_unit.sv =====
// Route prefix table: add, remove, first-match find and mark unreachable.
// Add and a bad-index remove or mark go straight to S_DONE; remove passes S_MOVE;
// find scans slots from index 0 in S_FIND until a hit or the last valid slot;
// mark passes S_MKEY, then S_MARK over every valid slot. One compare unit.
// Throughput: one item at a time; input is ready again once the result is
// in the output register. Reset clears the route count; table RAM is not cleared.
// ============================================================================
// route_prefix_table_unit
// Bounded IPv4 route table with a small sequencer over one table RAM and
// one shared prefix compare unit.
// ============================================================================
`default_nettype none

module route_prefix_table_unit #(
    parameter int TABLE_DEPTH = rpt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [rpt_pkg::REQ_W-1:0]         req_type,
    input  wire logic [rpt_pkg::ADDR_W-1:0]        new_network,
    input  wire logic [rpt_pkg::PREFIX_W-1:0]      new_prefix,
    input  wire logic [rpt_pkg::ADDR_W-1:0]        new_router,
    input  wire logic [rpt_pkg::REACH_W-1:0]       new_reach,
    input  wire logic [rpt_pkg::INDEX_W-1:0]       entry_index,
    input  wire logic [rpt_pkg::ADDR_W-1:0]        lookup_addr,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [rpt_pkg::STATUS_W-1:0]      status,
    output logic      [rpt_pkg::INDEX_W-1:0]       match_index,
    output logic      [rpt_pkg::ADDR_W-1:0]        match_router,
    output logic      [rpt_pkg::REACH_W-1:0]       match_reach,
    output logic      [rpt_pkg::COUNT_W-1:0]       route_count
);

    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W     = (CNT_W > rpt_pkg::INDEX_W) ? CNT_W : rpt_pkg::INDEX_W;
    localparam int OUT_IDX_W = rpt_pkg::INDEX_W;
    localparam int OUT_CNT_W = rpt_pkg::COUNT_W;
    localparam int ENTRY_W   = $bits(rpt_pkg::route_entry_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_FIND,
        S_MKEY,
        S_MARK,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rpt_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [OUT_IDX_W-1:0]            match_index_reg, match_index_next;
    logic [rpt_pkg::ADDR_W-1:0]      match_router_reg, match_router_next;
    logic [rpt_pkg::REACH_W-1:0]     match_reach_reg, match_reach_next;
    logic [OUT_CNT_W-1:0]            route_count_reg, route_count_next;

    // Work registers of the item in flight
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [IDX_W-1:0]                scan_reg, scan_next;
    logic [rpt_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic [rpt_pkg::ADDR_W-1:0]      key_net_reg, key_net_next;
    logic [rpt_pkg::PREFIX_W-1:0]    key_pre_reg, key_pre_next;
    rpt_pkg::status_t                res_status_reg, res_status_next;
    logic [IDX_W-1:0]                res_idx_reg, res_idx_next;
    logic [rpt_pkg::ADDR_W-1:0]      res_router_reg, res_router_next;
    logic [rpt_pkg::REACH_W-1:0]     res_reach_reg, res_reach_next;

    // Table RAM and compare unit hookup
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    rpt_pkg::route_entry_t           wr_entry;
    logic [IDX_W-1:0]                rd_addr;
    logic [ENTRY_W-1:0]              rd_raw;
    rpt_pkg::route_entry_t           rd_entry;
    logic [rpt_pkg::ADDR_W-1:0]      cmp_net;
    logic [rpt_pkg::PREFIX_W-1:0]    cmp_pre;
    logic [rpt_pkg::ADDR_W-1:0]      cmp_probe;
    logic                            cmp_hit;

    logic                            in_take;
    logic                            out_free;
    logic                            table_full;
    logic                            idx_bad;
    logic [IDX_W-1:0]                last_idx;
    logic [IDX_W-1:0]                in_idx;
    logic                            scan_last;

    rpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_entry = rpt_pkg::route_entry_t'(rd_raw);

    // Shared compare: find tests a slot against the lookup address,
    // mark tests the chosen slot's prefix against each slot's router
    always_comb
    begin
        if (state_reg == S_MARK)
        begin
            cmp_net   = key_net_reg;
            cmp_pre   = key_pre_reg;
            cmp_probe = rd_entry.router;
        end
        else
        begin
            cmp_net   = rd_entry.network;
            cmp_pre   = rd_entry.prefix;
            cmp_probe = addr_reg;
        end
    end

    rpt_match u_match (
        .network (cmp_net),
        .prefix  (cmp_pre),
        .probe   (cmp_probe),
        .hit     (cmp_hit)
    );

    // Handshake and request checks
    assign in_stall   = (state_reg != S_IDLE);
    assign in_take    = in_valid && (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign table_full = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign idx_bad    = (CMP_W'(entry_index) >= CMP_W'(count_reg));
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));
    assign in_idx     = IDX_W'(entry_index);
    assign scan_last  = (scan_reg == last_idx);

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        match_index_next  = match_index_reg;
        match_router_next = match_router_reg;
        match_reach_next  = match_reach_reg;
        route_count_next  = route_count_reg;

        idx_next          = idx_reg;
        scan_next         = scan_reg;
        addr_next         = addr_reg;
        key_net_next      = key_net_reg;
        key_pre_next      = key_pre_reg;
        res_status_next   = res_status_reg;
        res_idx_next      = res_idx_reg;
        res_router_next   = res_router_reg;
        res_reach_next    = res_reach_reg;

        wr_en             = 1'b0;
        wr_addr           = scan_reg;
        wr_entry          = rd_entry;
        rd_addr           = IDX_W'(scan_reg + IDX_W'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                idx_next        = in_idx;
                addr_next       = lookup_addr;
                scan_next       = '0;
                res_status_next = rpt_pkg::ST_OK;
                res_idx_next    = '0;
                res_router_next = '0;
                res_reach_next  = '0;
                rd_addr         = '0;
                if (in_take)
                begin
                    unique case (rpt_pkg::req_t'(req_type))
                        rpt_pkg::REQ_ADD:
                        begin
                            state_next = S_DONE;
                            if (table_full)
                            begin
                                res_status_next = rpt_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en            = 1'b1;
                                wr_addr          = IDX_W'(count_reg);
                                wr_entry.network = new_network;
                                wr_entry.prefix  = new_prefix;
                                wr_entry.router  = new_router;
                                wr_entry.reach   = new_reach;
                                count_next       = count_reg + CNT_W'(1);
                            end
                        end
                        rpt_pkg::REQ_REMOVE:
                        begin
                            rd_addr = last_idx;
                            if (idx_bad)
                            begin
                                res_status_next = rpt_pkg::ST_BADIDX;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MOVE;
                            end
                        end
                        rpt_pkg::REQ_FIND:
                        begin
                            res_status_next = rpt_pkg::ST_NOMATCH;
                            if (count_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FIND;
                            end
                        end
                        rpt_pkg::REQ_MARK:
                        begin
                            rd_addr = in_idx;
                            if (idx_bad)
                            begin
                                res_status_next = rpt_pkg::ST_BADIDX;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_MKEY;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // Last valid slot moves into the freed one
            S_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                count_next = count_reg - CNT_W'(1);
                state_next = S_DONE;
            end

            // One slot compared per cycle, lowest index first
            S_FIND:
            begin
                scan_next = IDX_W'(scan_reg + IDX_W'(1));
                if (cmp_hit)
                begin
                    res_status_next = rpt_pkg::ST_OK;
                    res_idx_next    = scan_reg;
                    res_router_next = rd_entry.router;
                    res_reach_next  = rd_entry.reach;
                    state_next      = S_DONE;
                end
                else if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end

            // Chosen slot's network and prefix become the search key
            S_MKEY:
            begin
                key_net_next = rd_entry.network;
                key_pre_next = rd_entry.prefix;
                rd_addr      = '0;
                scan_next    = '0;
                state_next   = S_MARK;
            end

            // Clear reach of the chosen slot and of every covered router
            S_MARK:
            begin
                scan_next      = IDX_W'(scan_reg + IDX_W'(1));
                wr_entry.reach = '0;
                wr_addr        = scan_reg;
                wr_en          = cmp_hit || (scan_reg == idx_reg);
                if (scan_last)
                begin
                    state_next = S_DONE;
                end
            end

            // Hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    match_index_next  = OUT_IDX_W'(res_idx_reg);
                    match_router_next = res_router_reg;
                    match_reach_next  = res_reach_reg;
                    route_count_next  = OUT_CNT_W'(count_reg);
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, count and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            match_index_reg  <= '0;
            match_router_reg <= '0;
            match_reach_reg  <= '0;
            route_count_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            match_index_reg  <= match_index_next;
            match_router_reg <= match_router_next;
            match_reach_reg  <= match_reach_next;
            route_count_reg  <= route_count_next;
        end
    end

    // Work registers, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        scan_reg       <= scan_next;
        addr_reg       <= addr_next;
        key_net_reg    <= key_net_next;
        key_pre_reg    <= key_pre_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_router_reg <= res_router_next;
        res_reach_reg  <= res_reach_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign match_index  = match_index_reg;
    assign match_router = match_router_reg;
    assign match_reach  = match_reach_reg;
    assign route_count  = route_count_reg;

    // Checks

    // Route count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("route count beyond table size");

    // Table writes while idle only come from an accepted add
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == S_IDLE) |->
            (in_valid && req_type == rpt_pkg::REQ_ADD))
        else $error("table write while idle without an add");

    // Scan index stays within the valid slots
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND || state_reg == S_MARK) |->
            (CNT_W'(scan_reg) < count_reg))
        else $error("scan past the last valid slot");

    // A table-full result reports a full table
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == rpt_pkg::ST_FULL) |->
            (route_count == OUT_CNT_W'(TABLE_DEPTH)))
        else $error("table full reported with free slots");

endmodule

`default_nettype wire

// ===== rtl/rpt_ram.sv =====
// ============================================================================
// rpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module rpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/rpt_match.sv =====
// ============================================================================
// rpt_match
// Prefix coverage compare: does a route's network/prefix cover an address.
// Prefix zero covers everything; prefixes of 32 and above use a full mask.
// ============================================================================
`default_nettype none

module rpt_match (
    input  wire logic [rpt_pkg::ADDR_W-1:0]   network,
    input  wire logic [rpt_pkg::PREFIX_W-1:0] prefix,
    input  wire logic [rpt_pkg::ADDR_W-1:0]   probe,
    output logic                              hit
);

    logic [rpt_pkg::ADDR_W-1:0] mask;

    // Top prefix bits set; shifting by 32 or more leaves the full mask
    assign mask = ~(rpt_pkg::ADDR_ONES >> prefix);

    assign hit = (prefix == '0) || (network == (probe & mask));

endmodule

`default_nettype wire

// ===== sim/route_table_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// route_table_checker
// Watches both channels of the route prefix table. Every request item that
// is taken in is applied to a private copy of the table, which yields the
// reply that the block must return. Replies are compared field by field,
// in order; every disagreement is counted and the first 50 are printed.
// ============================================================================

module route_table_checker
    import rpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [ADDR_W-1:0]   new_network,
    input  logic [PREFIX_W-1:0] new_prefix,
    input  logic [ADDR_W-1:0]   new_router,
    input  logic [REACH_W-1:0]  new_reach,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic [ADDR_W-1:0]   lookup_addr,

    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [INDEX_W-1:0]  match_index,
    input  logic [ADDR_W-1:0]   match_router,
    input  logic [REACH_W-1:0]  match_reach,
    input  logic [COUNT_W-1:0]  route_count,

    input  logic                run_done,
    output int                  pending,
    output int                  mismatches
);

    localparam int DEPTH = TABLE_DEPTH_DEF;

    // One reply item as the block should return it
    typedef struct {
        status_t             st;
        logic [INDEX_W-1:0]  slot;
        logic [ADDR_W-1:0]   router;
        logic [REACH_W-1:0]  reach;
        logic [COUNT_W-1:0]  count;
    } table_reply_t;

    // Private copy of the route table
    logic [ADDR_W-1:0]   slot_net    [DEPTH];
    logic [PREFIX_W-1:0] slot_prefix [DEPTH];
    logic [ADDR_W-1:0]   slot_router [DEPTH];
    logic [REACH_W-1:0]  slot_reach  [DEPTH];
    int                  used_slots;

    table_reply_t        table_replies[$];
    bit                  leftover_seen;

    // pending and mismatches start at zero as int variables
    initial
    begin
        used_slots    = 0;
        leftover_seen = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("%0t ns: route table mismatch: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    // Prefix 0 covers everything; prefixes of 32 and up compare all bits
    function automatic logic slot_covers(input int slot, input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] mask;
        if (slot_prefix[slot] == '0)
            return 1'b1;
        if (slot_prefix[slot] >= PREFIX_W'(32))
            mask = ADDR_ONES;
        else
            mask = ADDR_ONES << (32 - int'(slot_prefix[slot]));
        return slot_net[slot] == (addr & mask);
    endfunction

    // Apply one request to the table copy and return the reply it causes
    function automatic table_reply_t apply_table_request(
        input req_t                kind,
        input logic [ADDR_W-1:0]   net,
        input logic [PREFIX_W-1:0] pre,
        input logic [ADDR_W-1:0]   rtr,
        input logic [REACH_W-1:0]  rch,
        input logic [INDEX_W-1:0]  idx,
        input logic [ADDR_W-1:0]   addr
    );
        table_reply_t reply;
        int           last;
        bit           found;
        reply.st     = ST_OK;
        reply.slot   = '0;
        reply.router = '0;
        reply.reach  = '0;
        found        = 1'b0;
        case (kind)
            REQ_ADD:
            begin
                if (used_slots >= DEPTH)
                    reply.st = ST_FULL;
                else
                begin
                    slot_net[used_slots]    = net;
                    slot_prefix[used_slots] = pre;
                    slot_router[used_slots] = rtr;
                    slot_reach[used_slots]  = rch;
                    used_slots = used_slots + 1;
                end
            end
            REQ_REMOVE:
            begin
                if (int'(idx) >= used_slots)
                    reply.st = ST_BADIDX;
                else
                begin
                    // last route fills the hole
                    last = used_slots - 1;
                    slot_net[idx]    = slot_net[last];
                    slot_prefix[idx] = slot_prefix[last];
                    slot_router[idx] = slot_router[last];
                    slot_reach[idx]  = slot_reach[last];
                    used_slots = last;
                end
            end
            REQ_FIND:
            begin
                reply.st = ST_NOMATCH;
                for (int i = 0; i < used_slots; i++)
                begin
                    if (!found && slot_covers(i, addr))
                    begin
                        found        = 1'b1;
                        reply.st     = ST_OK;
                        reply.slot   = INDEX_W'(i);
                        reply.router = slot_router[i];
                        reply.reach  = slot_reach[i];
                    end
                end
            end
            REQ_MARK:
            begin
                if (int'(idx) >= used_slots)
                    reply.st = ST_BADIDX;
                else
                begin
                    // chosen route plus every route whose router it covers
                    slot_reach[idx] = '0;
                    for (int i = 0; i < used_slots; i++)
                    begin
                        if (slot_covers(int'(idx), slot_router[i]))
                            slot_reach[i] = '0;
                    end
                end
            end
        endcase
        reply.count = COUNT_W'(used_slots);
        return reply;
    endfunction

    // Compare replies first, then record the request taken at this edge
    always @(posedge clk)
    begin : watch_channels
        table_reply_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (table_replies.size() == 0)
                    report_mismatch("reply item with no request waiting");
                else
                begin
                    want = table_replies.pop_front();
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d, want %0d", status, want.st));
                    if (match_index !== want.slot)
                        report_mismatch($sformatf("match_index %0d, want %0d",
                                                  match_index, want.slot));
                    if (match_router !== want.router)
                        report_mismatch($sformatf("match_router %h, want %h",
                                                  match_router, want.router));
                    if (match_reach !== want.reach)
                        report_mismatch($sformatf("match_reach %0d, want %0d",
                                                  match_reach, want.reach));
                    if (route_count !== want.count)
                        report_mismatch($sformatf("route_count %0d, want %0d",
                                                  route_count, want.count));
                end
            end
            if (in_valid && !in_stall)
                table_replies.push_back(apply_table_request(req_t'(req_type), new_network,
                                                            new_prefix, new_router, new_reach,
                                                            entry_index, lookup_addr));
            pending = table_replies.size();
            if (run_done && !leftover_seen)
            begin
                leftover_seen = 1'b1;
                if (table_replies.size() != 0)
                    report_mismatch($sformatf("%0d replies never arrived",
                                              table_replies.size()));
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives the route prefix table with a directed opening (empty and full
// table, all prefix extremes, bad indices, moves on remove, cascading mark)
// and then randomized requests built around a pool of recent networks so
// that finds hit and marks spread. Both channels stall at random; the
// checker beside the block predicts and compares every reply.
// ============================================================================

module testbench;

    import rpt_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int QUIET_ITEMS  = 100;
    localparam int STALL_LIMIT  = 2000;

    logic                clk = 1'b0;
    logic                rst_n;

    logic                in_valid;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type;
    logic [ADDR_W-1:0]   new_network;
    logic [PREFIX_W-1:0] new_prefix;
    logic [ADDR_W-1:0]   new_router;
    logic [REACH_W-1:0]  new_reach;
    logic [INDEX_W-1:0]  entry_index;
    logic [ADDR_W-1:0]   lookup_addr;

    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  match_index;
    logic [ADDR_W-1:0]   match_router;
    logic [REACH_W-1:0]  match_reach;
    logic [COUNT_W-1:0]  route_count;

    logic                run_done;
    logic                quiet;
    int                  pending_replies;
    int                  mismatch_count;
    int                  idle_cycles;

    // Recently added networks, used to aim finds and routers
    logic [ADDR_W-1:0]   pool_net [8];
    logic [PREFIX_W-1:0] pool_pre [8];
    int                  pool_fill;
    int                  pool_next;

    always #1 clk = ~clk;

    route_prefix_table_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .new_network  (new_network),
        .new_prefix   (new_prefix),
        .new_router   (new_router),
        .new_reach    (new_reach),
        .entry_index  (entry_index),
        .lookup_addr  (lookup_addr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .match_index  (match_index),
        .match_router (match_router),
        .match_reach  (match_reach),
        .route_count  (route_count)
    );

    route_table_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .new_network  (new_network),
        .new_prefix   (new_prefix),
        .new_router   (new_router),
        .new_reach    (new_reach),
        .entry_index  (entry_index),
        .lookup_addr  (lookup_addr),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .match_index  (match_index),
        .match_router (match_router),
        .match_reach  (match_reach),
        .route_count  (route_count),
        .run_done     (run_done),
        .pending      (pending_replies),
        .mismatches   (mismatch_count)
    );

    // Watchdog: too long with no item moving on either channel
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Reply side back-pressure: random stall bursts, none in the quiet tail
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (quiet)
            begin
                out_stall = 1'b0;
                @(negedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            else
            begin
                out_stall = 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    function automatic logic [ADDR_W-1:0] net_mask(input logic [PREFIX_W-1:0] pre);
        if (pre == '0)
            return '0;
        if (pre >= PREFIX_W'(32))
            return ADDR_ONES;
        return ADDR_ONES << (32 - int'(pre));
    endfunction

    // Random filler for fields a request does not use
    function automatic logic [PREFIX_W-1:0] any_pre();
        return PREFIX_W'($urandom);
    endfunction

    function automatic logic [REACH_W-1:0] any_reach();
        return REACH_W'($urandom);
    endfunction

    function automatic logic [INDEX_W-1:0] any_idx();
        return INDEX_W'($urandom);
    endfunction

    // Present one request item at a falling edge and hold it until taken
    task automatic send_request(
        input req_t                kind,
        input logic [ADDR_W-1:0]   net,
        input logic [PREFIX_W-1:0] pre,
        input logic [ADDR_W-1:0]   rtr,
        input logic [REACH_W-1:0]  rch,
        input logic [INDEX_W-1:0]  idx,
        input logic [ADDR_W-1:0]   addr
    );
        req_type    = kind;
        new_network = net;
        new_prefix  = pre;
        new_router  = rtr;
        new_reach   = rch;
        entry_index = idx;
        lookup_addr = addr;
        in_valid    = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic idle_input(input int cycles);
        in_valid = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Hold off until every reply in flight has come back
    task automatic drain_replies();
        in_valid = 1'b0;
        do
            @(negedge clk);
        while (pending_replies != 0);
    endtask

    // Random request, mostly aimed at networks already in the table
    task automatic send_random_request(input int add_weight);
        req_t                kind;
        logic [ADDR_W-1:0]   net;
        logic [PREFIX_W-1:0] pre;
        logic [ADDR_W-1:0]   rtr;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   base;
        int                  roll;
        int                  j;

        roll = $urandom_range(0, 99);
        if (roll < add_weight)
            kind = REQ_ADD;
        else
        begin
            roll = $urandom_range(0, 3);
            kind = (roll < 2) ? REQ_FIND : (roll == 2) ? REQ_REMOVE : REQ_MARK;
        end

        // prefix: zero, oversized, full and ordinary lengths
        case ($urandom_range(0, 9))
            0:       pre = '0;
            1:       pre = PREFIX_W'($urandom_range(33, 63));
            2:       pre = PREFIX_W'(32);
            default: pre = PREFIX_W'($urandom_range(1, 31));
        endcase

        // network: reuse a pool network now and then; a few stay unmasked
        if (pool_fill > 0 && $urandom_range(0, 2) == 0)
            base = pool_net[$urandom_range(0, pool_fill - 1)];
        else
            base = $urandom;
        net = ($urandom_range(0, 6) == 0) ? base : (base & net_mask(pre));

        // router: often inside a known network so marks spread
        if (pool_fill > 0 && $urandom_range(0, 1) == 0)
        begin
            j   = $urandom_range(0, pool_fill - 1);
            rtr = pool_net[j] | ($urandom & ~net_mask(pool_pre[j]));
        end
        else
            rtr = $urandom;

        // lookup: mostly a host inside a known network
        if (pool_fill > 0 && $urandom_range(0, 9) < 7)
        begin
            j    = $urandom_range(0, pool_fill - 1);
            addr = pool_net[j] | ($urandom & ~net_mask(pool_pre[j]));
        end
        else
        begin
            case ($urandom_range(0, 5))
                0:       addr = '0;
                1:       addr = ADDR_ONES;
                default: addr = $urandom;
            endcase
        end

        if (kind == REQ_ADD)
        begin
            pool_net[pool_next] = net;
            pool_pre[pool_next] = pre;
            pool_next = (pool_next + 1) % 8;
            if (pool_fill < 8)
                pool_fill = pool_fill + 1;
        end

        send_request(kind, net, pre, rtr, REACH_W'($urandom), INDEX_W'($urandom_range(0, 7)),
                     addr);
    endtask

    // Main stimulus
    initial
    begin
        int add_weight;
        bit sender_calm;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_ADD;
        new_network = '0;
        new_prefix  = '0;
        new_router  = '0;
        new_reach   = '0;
        entry_index = '0;
        lookup_addr = '0;
        run_done    = 1'b0;
        quiet       = 1'b0;
        pool_fill   = 0;
        pool_next   = 0;
        add_weight  = 45;
        sender_calm = 1'b0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty table: nothing to find, every index out of range
        send_request(REQ_FIND,   $urandom, any_pre(), $urandom, any_reach(), 3'd0, 32'h0A0B_0C0D);
        send_request(REQ_REMOVE, $urandom, any_pre(), $urandom, any_reach(), 3'd0, $urandom);
        send_request(REQ_MARK,   $urandom, any_pre(), $urandom, any_reach(), 3'd7, $urandom);

        // Fill all slots: prefix 8, 24, 32, zero, oversized, 63, 1, unmasked net
        send_request(REQ_ADD, 32'h0A00_0000, 6'd8,  32'h0A01_0101, 8'hFF, any_idx(), $urandom);
        send_request(REQ_ADD, 32'hC0A8_0100, 6'd24, 32'h0A00_0001, 8'h01, any_idx(), $urandom);
        send_request(REQ_ADD, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 8'h80, any_idx(), $urandom);
        send_request(REQ_ADD, 32'h1234_5678, 6'd0,  32'h0102_0304, 8'h05, any_idx(), $urandom);
        send_request(REQ_ADD, 32'hAC10_0000, 6'd40, 32'hC0A8_0105, 8'h07, any_idx(), $urandom);
        send_request(REQ_ADD, 32'h0000_0000, 6'd63, 32'h0000_0000, 8'h00, any_idx(), $urandom);
        send_request(REQ_ADD, 32'h8000_0000, 6'd1,  32'h8000_0000, 8'hC8, any_idx(), $urandom);
        send_request(REQ_ADD, 32'hC0A8_0101, 6'd24, 32'h0000_0012, 8'h09, any_idx(), $urandom);
        // full table
        send_request(REQ_ADD, 32'h5555_0000, 6'd16, 32'h5555_0001, 8'h33, any_idx(), $urandom);

        // First-match finds
        send_request(REQ_FIND, $urandom, any_pre(), $urandom, any_reach(), any_idx(),
                     32'h0A0B_0C0D);
        send_request(REQ_FIND, $urandom, any_pre(), $urandom, any_reach(), any_idx(),
                     32'hFFFF_FFFF);
        send_request(REQ_FIND, $urandom, any_pre(), $urandom, any_reach(), any_idx(),
                     32'hC0A8_01FE);
        send_request(REQ_FIND, $urandom, any_pre(), $urandom, any_reach(), any_idx(),
                     32'h5555_5555);

        // Remove the match-all route; last route moves into its slot
        send_request(REQ_REMOVE, $urandom, any_pre(), $urandom, any_reach(), 3'd3, $urandom);
        send_request(REQ_FIND, $urandom, any_pre(), $urandom, any_reach(), any_idx(),
                     32'h5555_5555);
        send_request(REQ_FIND, $urandom, any_pre(), $urandom, any_reach(), any_idx(),
                     32'h0000_0000);

        // Mark 10/8 unreachable, which also hits the route via 10.0.0.1
        send_request(REQ_MARK, $urandom, any_pre(), $urandom, any_reach(), 3'd0, $urandom);
        send_request(REQ_FIND, $urandom, any_pre(), $urandom, any_reach(), any_idx(),
                     32'hC0A8_0180);

        // Remove the last slot, then indices past the end
        send_request(REQ_REMOVE, $urandom, any_pre(), $urandom, any_reach(), 3'd6, $urandom);
        send_request(REQ_MARK,   $urandom, any_pre(), $urandom, any_reach(), 3'd7, $urandom);
        send_request(REQ_REMOVE, $urandom, any_pre(), $urandom, any_reach(), 3'd7, $urandom);
        send_request(REQ_FIND,   $urandom, any_pre(), $urandom, any_reach(), any_idx(),
                     32'hAC10_FFFF);

        drain_replies();

        // Random part: the add/remove mix shifts so the table fills and empties
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       add_weight = 20;
                    1:       add_weight = 45;
                    default: add_weight = 70;
                endcase
            end
            if (n % 32 == 0)
                sender_calm = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            if (!quiet && n % 150 == 75)
                drain_replies();
            if (!quiet && !sender_calm && $urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 12));
            send_random_request(add_weight);
        end

        // Let the last replies come back, then settle
        in_valid = 1'b0;
        while (pending_replies != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        run_done = 1'b1;
        repeat (2) @(negedge clk);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
